// ===== src/dtls_pkg.sv =====
package dtls_pkg;

  localparam int RANGE_W = 24;
  localparam int LABEL_W = 17;
  localparam int IN_LABEL_W = 16;
  localparam int PIX_W = 9;
  localparam int DIM_W = 10;
  localparam int CNT_W = 8;
  localparam int CMD_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  // signed pixel coordinate: covers a centre plus or minus the widest box
  localparam int COORD_W = 11;
  localparam int WORD_W = LABEL_W + RANGE_W;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SPLAT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPLAT_EN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RNG  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_Y = 3'd5;

  localparam logic [LABEL_W-1:0] LABEL_EMPTY = 17'h1FFFF;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 8'hFF;

endpackage

// ===== src/dtls_if.sv =====
interface dtls_in_if import dtls_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [PIX_W-1:0]        pixel_u;
  logic [PIX_W-1:0]        pixel_v;
  logic [RANGE_W-1:0]      point_range;
  logic [RANGE_W-1:0]      point_depth;
  logic [IN_LABEL_W-1:0]   point_label;

  modport source (output valid, cmd, pixel_u, pixel_v, point_range, point_depth, point_label,
                  input ready);
  modport sink (input valid, cmd, pixel_u, pixel_v, point_range, point_depth, point_label,
                output ready);
endinterface

interface dtls_out_if import dtls_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [LABEL_W-1:0] read_label;
  logic [RANGE_W-1:0]        read_range;
  logic [CNT_W-1:0]          pixels_written;

  modport source (output valid, read_label, read_range, pixels_written, input ready);
  modport sink (input valid, read_label, read_range, pixels_written, output ready);
endinterface

// ===== src/depth_tested_label_splatter_top.sv =====
// Depth-tested label splatter. A range and label entry per pixel sits in one
// single-port-read, single-port-write memory of MAX_WIDTH x MAX_HEIGHT words.
// Every word gives exactly one result word. Clear sweeps the memory one entry
// a cycle, and it must precede any splat or read. An in-image read returns
// the stored entry of its pixel. In a splat the radius unit adds depth once
// a cycle up to the larger radius (at most MAX_SPLAT_RADIUS), then the box
// is scanned one pixel a cycle with a pipelined read, compare and write-back;
// out-of-image pixels still use their cycle. A new word is taken only when
// the previous one is finished, though a finished result may still wait on
// the output.
module depth_tested_label_splatter_top
  import dtls_pkg::*;
#(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_SPLAT_RADIUS = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dtls_in_if.sink               in_ch,
  dtls_out_if.source            out_ch,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW = (MAX_SPLAT_RADIUS > 0) ? $clog2(MAX_SPLAT_RADIUS + 1) : 1;
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [12:0] MAXW_C = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH_C = 13'(MAX_HEIGHT);

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_RADIUS, S_SCAN, S_DRAIN, S_RD_ISS, S_RD_WAIT, S_DONE
  } state_t;

  // configuration
  logic               splat_en_r;
  logic [DIM_W-1:0]   img_w_r;
  logic [DIM_W-1:0]   img_h_r;
  logic [RANGE_W-1:0] max_range_r;
  logic [RANGE_W-1:0] factor_x_r;
  logic [RANGE_W-1:0] factor_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      splat_en_r  <= 1'b0;
      img_w_r     <= 10'd512;
      img_h_r     <= 10'd512;
      max_range_r <= 24'hFFFFFF;
      factor_x_r  <= '0;
      factor_y_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SPLAT_EN: splat_en_r  <= cfg_wdata[0];
        CFG_WIDTH:    img_w_r     <= cfg_wdata[DIM_W-1:0];
        CFG_HEIGHT:   img_h_r     <= cfg_wdata[DIM_W-1:0];
        CFG_MAX_RNG:  max_range_r <= cfg_wdata[RANGE_W-1:0];
        CFG_FACTOR_X: factor_x_r  <= cfg_wdata[RANGE_W-1:0];
        CFG_FACTOR_Y: factor_y_r  <= cfg_wdata[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] w_act;
  logic [DIM_W-1:0] h_act;

  assign w_act = ({3'b0, img_w_r} > MAXW_C) ? DIM_W'(MAX_WIDTH) : img_w_r;
  assign h_act = ({3'b0, img_h_r} > MAXH_C) ? DIM_W'(MAX_HEIGHT) : img_h_r;

  // item and sequencer state
  state_t                    state_r;
  logic [PIX_W-1:0]          u_r;
  logic [PIX_W-1:0]          v_r;
  logic [RANGE_W-1:0]        range_r;
  logic [IN_LABEL_W-1:0]     label_r;
  logic [RW-1:0]             rx_r;
  logic [RW-1:0]             ry_r;
  logic signed [COORD_W-1:0] un_r;
  logic signed [COORD_W-1:0] vn_r;
  logic [AW-1:0]             clr_r;
  logic                      pend_r;
  logic [AW-1:0]             paddr_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [LABEL_W-1:0] res_label_r;
  logic [RANGE_W-1:0]        res_range_r;
  logic                      out_valid_r;
  logic signed [LABEL_W-1:0] out_label_r;
  logic [RANGE_W-1:0]        out_range_r;
  logic [CNT_W-1:0]          out_cnt_r;

  logic                      accept;
  logic                      in_bounds;
  logic                      rad_start;
  logic                      rad_done;
  logic [RW-1:0]             rad_x;
  logic [RW-1:0]             rad_y;
  logic signed [COORD_W-1:0] u_s;
  logic signed [COORD_W-1:0] v_s;
  logic signed [COORD_W-1:0] u_hi;
  logic signed [COORD_W-1:0] v_lo;
  logic signed [COORD_W-1:0] v_hi;
  logic                      in_box;
  logic [AW-1:0]             scan_addr;
  logic [AW-1:0]             read_addr;
  logic                      mem_wr_en;
  logic [AW-1:0]             mem_wr_addr;
  logic [WORD_W-1:0]         mem_wr_data;
  logic                      mem_rd_en;
  logic [AW-1:0]             mem_rd_addr;
  logic [WORD_W-1:0]         mem_rd_data;
  logic                      win;
  logic                      load_out;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_bounds = ({1'b0, in_ch.pixel_u} < w_act) && ({1'b0, in_ch.pixel_v} < h_act);
  assign rad_start = accept && (in_ch.cmd == CMD_SPLAT);

  assign u_s  = $signed(COORD_W'(u_r));
  assign v_s  = $signed(COORD_W'(v_r));
  assign u_hi = u_s + $signed(COORD_W'(rx_r));
  assign v_lo = v_s - $signed(COORD_W'(ry_r));
  assign v_hi = v_s + $signed(COORD_W'(ry_r));

  assign in_box = (un_r >= 0) && (un_r < $signed(COORD_W'(w_act)))
               && (vn_r >= 0) && (vn_r < $signed(COORD_W'(h_act)));

  assign scan_addr = AW'(vn_r[COORD_W-2:0]) * ROW_STRIDE + AW'(un_r[COORD_W-2:0]);
  assign read_addr = AW'(v_r) * ROW_STRIDE + AW'(u_r);

  assign win = pend_r && (range_r < mem_rd_data[RANGE_W-1:0]);

  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_r;
      mem_wr_data = {LABEL_EMPTY, max_range_r};
    end else begin
      mem_wr_en   = win;
      mem_wr_addr = paddr_r;
      mem_wr_data = {1'b0, label_r, range_r};
    end
  end

  always_comb begin
    if (state_r == S_SCAN) begin
      mem_rd_en   = in_box;
      mem_rd_addr = scan_addr;
    end else begin
      mem_rd_en   = (state_r == S_RD_ISS);
      mem_rd_addr = read_addr;
    end
  end

  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= (state_r == S_SCAN) && in_box;
      if (win && cnt_r != CNT_MAX) begin
        cnt_r <= cnt_r + 1'b1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            u_r         <= in_ch.pixel_u;
            v_r         <= in_ch.pixel_v;
            range_r     <= in_ch.point_range;
            label_r     <= in_ch.point_label;
            res_label_r <= '0;
            res_range_r <= '0;
            cnt_r       <= '0;
            clr_r       <= '0;
            case (in_ch.cmd)
              CMD_CLEAR: state_r <= S_CLEAR;
              CMD_SPLAT: state_r <= S_RADIUS;
              CMD_READ: begin
                if (in_bounds) begin
                  state_r <= S_RD_ISS;
                end else begin
                  res_label_r <= $signed(LABEL_EMPTY);
                  res_range_r <= max_range_r;
                  state_r     <= S_DONE;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == LAST_ADDR) begin
            state_r <= S_DONE;
          end
        end
        S_RADIUS: begin
          if (rad_done) begin
            rx_r    <= rad_x;
            ry_r    <= rad_y;
            un_r    <= u_s - $signed(COORD_W'(rad_x));
            vn_r    <= v_s - $signed(COORD_W'(rad_y));
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          paddr_r <= scan_addr;
          if (vn_r == v_hi) begin
            vn_r <= v_lo;
            if (un_r == u_hi) begin
              state_r <= S_DRAIN;
            end else begin
              un_r <= un_r + 1'b1;
            end
          end else begin
            vn_r <= vn_r + 1'b1;
          end
        end
        S_DRAIN: begin
          // last write-back lands here; count settles next cycle
          state_r <= S_DONE;
        end
        S_RD_ISS: state_r <= S_RD_WAIT;
        S_RD_WAIT: begin
          res_label_r <= $signed(mem_rd_data[WORD_W-1:RANGE_W]);
          res_range_r <= mem_rd_data[RANGE_W-1:0];
          state_r     <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (load_out) begin
        out_valid_r <= 1'b1;
        out_label_r <= res_label_r;
        out_range_r <= res_range_r;
        out_cnt_r   <= cnt_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  dtls_radius #(
    .MAX_R (MAX_SPLAT_RADIUS),
    .RW    (RW)
  ) u_radius (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rad_start),
    .factor_x (splat_en_r ? factor_x_r : '0),
    .factor_y (splat_en_r ? factor_y_r : '0),
    .depth    (in_ch.point_depth),
    .done     (rad_done),
    .rad_x    (rad_x),
    .rad_y    (rad_y)
  );

  dtls_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_label     = out_label_r;
  assign out_ch.read_range     = out_range_r;
  assign out_ch.pixels_written = out_cnt_r;

endmodule

// ===== src/dtls_store.sv =====
module dtls_store
  import dtls_pkg::*;
#(
  parameter int DEPTH = 262144,
  parameter int AW = 18
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/dtls_radius.sv =====
// ceil(factor / depth) by repeated addition of depth, one step per cycle,
// both axes side by side, stopping at the radius limit.
module dtls_radius
  import dtls_pkg::*;
#(
  parameter int MAX_R = 7,
  parameter int RW = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [RANGE_W-1:0] factor_x,
  input  logic [RANGE_W-1:0] factor_y,
  input  logic [RANGE_W-1:0] depth,
  output logic               done,
  output logic [RW-1:0]      rad_x,
  output logic [RW-1:0]      rad_y
);

  localparam int ACC_W = RANGE_W + RW;
  localparam logic [RW-1:0] R_LIMIT = RW'(MAX_R);

  logic               busy_r;
  logic               done_r;
  logic [RW-1:0]      rx_r;
  logic [RW-1:0]      ry_r;
  logic [ACC_W-1:0]   accx_r;
  logic [ACC_W-1:0]   accy_r;
  logic [RANGE_W-1:0] fx_r;
  logic [RANGE_W-1:0] fy_r;
  logic [RANGE_W-1:0] dep_r;
  logic               stop_x;
  logic               stop_y;

  assign stop_x = (rx_r == R_LIMIT) || (accx_r >= ACC_W'(fx_r));
  assign stop_y = (ry_r == R_LIMIT) || (accy_r >= ACC_W'(fy_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && !start && stop_x && stop_y;
      if (start) begin
        busy_r <= 1'b1;
        fx_r   <= factor_x;
        fy_r   <= factor_y;
        dep_r  <= depth;
        accx_r <= '0;
        accy_r <= '0;
        // zero depth with a live factor goes straight to the limit
        rx_r   <= (depth == '0 && factor_x != '0) ? R_LIMIT : '0;
        ry_r   <= (depth == '0 && factor_y != '0) ? R_LIMIT : '0;
      end else if (busy_r) begin
        if (stop_x && stop_y) begin
          busy_r <= 1'b0;
        end else begin
          if (!stop_x) begin
            accx_r <= accx_r + ACC_W'(dep_r);
            rx_r   <= rx_r + 1'b1;
          end
          if (!stop_y) begin
            accy_r <= accy_r + ACC_W'(dep_r);
            ry_r   <= ry_r + 1'b1;
          end
        end
      end
    end
  end

  assign done  = done_r;
  assign rad_x = rx_r;
  assign rad_y = ry_r;

endmodule
